// ===== src/command_frame_builder_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COMMAND_FRAME_BUILDER_CORE_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cfb_pkg.sv =====
package cfb_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 10;
    localparam int WIRE_LEN_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] SEQ_TOP   = 8'hFF;
    localparam logic [BYTE_W-1:0] SEQ_FIRST = 8'h01;

    // Request op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    // Last step index of each job kind
    localparam logic [STEP_W-1:0] HEAD_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] DATA_LAST_STEP = 4'd0;
    localparam logic [STEP_W-1:0] TAIL_LAST_STEP = 4'd4;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        JOB_HEAD,
        JOB_DATA,
        JOB_TAIL
    } t_job_kind;

    // One unit of work for the back end
    typedef struct packed {
        t_job_kind kind;
        t_byte     len_lo;
        t_byte     len_hi;
        t_byte     dst;
        t_byte     src;
        t_byte     dup;
        t_byte     seq;
        t_byte     op1;
        t_byte     op2;
        t_byte     data;
        t_byte     chk;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    function automatic logic length_ok(input logic [LEN_W-1:0] len);
        logic ok;
        case (len) inside
            10'd8, 10'd12, 10'd16, 10'd24, 10'd46, 10'd48,
            10'd62, 10'd64, 10'd512, 10'd640, 10'd1012: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== src/cfb_in_if.sv =====
interface cfb_in_if;
    import cfb_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  source_address;
    logic [BYTE_W-1:0]  dest_address;
    logic [BYTE_W-1:0]  duplicate_count;
    logic [BYTE_W-1:0]  opcode_first;
    logic [BYTE_W-1:0]  opcode_second;
    logic [BYTE_W-1:0]  payload_byte;

    modport source (
        output valid, op, frame_length, source_address, dest_address,
               duplicate_count, opcode_first, opcode_second, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, op, frame_length, source_address, dest_address,
               duplicate_count, opcode_first, opcode_second, payload_byte,
        output ready
    );
endinterface

// ===== src/cfb_out_if.sv =====
interface cfb_out_if;
    import cfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              run_last;

    modport source (output valid, out_byte, frame_end, run_last, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

// ===== src/cfb_cfg_if.sv =====
interface cfb_cfg_if;
    import cfb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/command_frame_builder_core.sv =====
// Command frame builder.
// i_in takes requests: op START opens a frame (header fields, frame_length),
// op DATA carries one payload byte. A START with an unlisted length, and DATA
// with no open frame, are taken and dropped with no output.
// o_out gives the frame one byte per cycle unless o_out stalls; run_last marks
// the final byte caused by a request and frame_end marks the end marker byte.
// i_cfg writes index 0 (start marker) and index 1 (end marker); always ready.
// Throughput: one request per cycle while the job queue has room. A START
// expands to 12 bytes, a middle DATA to 1 byte, the last DATA to 5 bytes;
// the back end emits one byte per cycle unless o_out stalls, so header runs
// fill the 4-entry queue. With the queue empty, a request's first byte goes
// through its queue entry and then the output register onto o_out.
// When o_out stalls the output register holds and the queue fills; i_in.ready
// drops only with the queue full.
// Reset (synchronous, active low) empties the queue and output register,
// closes any frame, sets the sequence number to 1 and both markers to 0.
module command_frame_builder_core #(
    parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfb_in_if.sink   i_in,
    cfb_cfg_if.sink  i_cfg,
    cfb_out_if.source o_out
);
    import cfb_pkg::*;

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;
    t_push             push;
    t_job              head;
    logic              head_valid;
    logic              full;
    logic              pop;

    assign i_cfg.ready = 1'b1;

    // Hold the marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_START_MARKER: r_start_marker <= i_cfg.data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    cfb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_pop          (pop),
        .o_out          (o_out)
    );
endmodule

// ===== src/cfb_front.sv =====
module cfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfb_in_if.sink        i_in,
    input  logic          i_full,
    output cfb_pkg::t_push o_push
);
    import cfb_pkg::*;

    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_open, n_open;
    logic              accept;
    t_push             push;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = push;

    // Classify the accepted request and build its job
    always_comb begin
        logic [WIRE_LEN_W-1:0] wire_len;
        logic [LEN_W-1:0]      left_dec;
        logic [BYTE_W-1:0]     xor_next;
        wire_len = {1'b0, i_in.frame_length} + WIRE_LEN_W'(4);
        left_dec = r_left - LEN_W'(1);
        xor_next = r_xor ^ i_in.payload_byte;
        n_seq    = r_seq;
        n_xor    = r_xor;
        n_left   = r_left;
        n_open   = r_open;
        push     = '0;
        push.job.len_lo = wire_len[BYTE_W-1:0];
        push.job.len_hi = BYTE_W'(wire_len[WIRE_LEN_W-1:BYTE_W]);
        push.job.dst    = i_in.dest_address;
        push.job.src    = i_in.source_address;
        push.job.dup    = i_in.duplicate_count;
        push.job.seq    = r_seq;
        push.job.op1    = i_in.opcode_first;
        push.job.op2    = i_in.opcode_second;
        push.job.data   = i_in.payload_byte;
        push.job.chk    = xor_next;
        push.job.kind   = JOB_DATA;
        if (accept) begin
            unique case (i_in.op)
                OP_START: begin
                    // Drop starts with an unlisted length
                    if (length_ok(i_in.frame_length)) begin
                        push.valid    = 1'b1;
                        push.job.kind = JOB_HEAD;
                        n_seq  = (r_seq == SEQ_TOP) ? SEQ_FIRST : r_seq + BYTE_W'(1);
                        n_xor  = i_in.duplicate_count ^ r_seq
                               ^ i_in.opcode_first ^ i_in.opcode_second;
                        n_left = i_in.frame_length - LEN_W'(4);
                        n_open = 1'b1;
                    end
                end
                OP_DATA: begin
                    // Drop payload with no open frame
                    if (r_open && r_left != '0) begin
                        push.valid = 1'b1;
                        n_left     = left_dec;
                        if (left_dec == '0) begin
                            push.job.kind = JOB_TAIL;
                            n_xor  = '0;
                            n_open = 1'b0;
                        end else begin
                            n_xor = xor_next;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= SEQ_FIRST;
            r_xor  <= '0;
            r_left <= '0;
            r_open <= 1'b0;
        end else begin
            r_seq  <= n_seq;
            r_xor  <= n_xor;
            r_left <= n_left;
            r_open <= n_open;
        end
    end
endmodule

// ===== src/cfb_queue.sv =====
module cfb_queue #(
    parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfb_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_valid,
    output cfb_pkg::t_job  o_head
);
    import cfb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end
endmodule

// ===== src/cfb_back.sv =====
module cfb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  cfb_pkg::t_job         i_head,
    input  logic [cfb_pkg::BYTE_W-1:0] i_start_marker,
    input  logic [cfb_pkg::BYTE_W-1:0] i_end_marker,
    output logic                  o_pop,
    cfb_out_if.source             o_out
);
    import cfb_pkg::*;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_frame_end, n_frame_end;
    logic              r_run_last;
    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] last_step;
    logic              out_free;
    logic              advance;
    logic              step_last;

    assign out_free  = !r_out_valid || o_out.ready;
    assign advance   = i_head_valid && out_free;
    assign step_last = (r_step == last_step);
    assign o_pop     = advance && step_last;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.frame_end = r_frame_end;
    assign o_out.run_last  = r_run_last;

    // Pick the byte for the current step of the head job
    always_comb begin
        n_out_byte  = '0;
        n_frame_end = 1'b0;
        last_step   = DATA_LAST_STEP;
        unique case (i_head.kind)
            JOB_HEAD: begin
                last_step = HEAD_LAST_STEP;
                case (r_step)
                    4'd0:    n_out_byte = i_start_marker;
                    4'd1:    n_out_byte = i_head.len_lo;
                    4'd2:    n_out_byte = i_head.len_hi;
                    4'd3:    n_out_byte = i_start_marker ^ i_head.len_lo ^ i_head.len_hi;
                    4'd4:    n_out_byte = i_head.dst;
                    4'd5:    n_out_byte = i_head.src;
                    4'd6:    n_out_byte = i_head.dup;
                    4'd7:    n_out_byte = i_head.seq;
                    4'd8:    n_out_byte = i_head.src;
                    4'd9:    n_out_byte = i_head.dst;
                    4'd10:   n_out_byte = i_head.op1;
                    4'd11:   n_out_byte = i_head.op2;
                    default: n_out_byte = '0;
                endcase
            end
            JOB_DATA: begin
                n_out_byte = i_head.data;
            end
            JOB_TAIL: begin
                last_step = TAIL_LAST_STEP;
                case (r_step)
                    4'd0:    n_out_byte = i_head.data;
                    4'd1:    n_out_byte = i_head.chk;
                    4'd4: begin
                        n_out_byte  = i_end_marker;
                        n_frame_end = 1'b1;
                    end
                    default: n_out_byte = '0;
                endcase
            end
            default: ;
        endcase
    end

    // Step within the job, restart on pop
    always_comb begin
        n_step = r_step;
        if (advance) begin
            n_step = step_last ? '0 : r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_step <= n_step;
            if (out_free) begin
                r_out_valid <= i_head_valid;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte  <= n_out_byte;
            r_frame_end <= n_frame_end;
            r_run_last  <= step_last;
        end
    end
endmodule

// ===== src/cfb_checker.sv =====
`include "command_frame_builder_core_defines.svh"

module cfb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cfb_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_frame_end,
    input logic                       i_run_last
);
    // Stalled output holds its byte
    `CFB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte), "stalled byte changed")
    // End marker always closes the request's run
    `CFB_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, i_out_valid && i_frame_end, i_run_last, "frame_end without run_last")
    // Nothing leaves in the cycle after reset
    `CFB_ASSERT_NOW(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid, "output valid right after reset")
endmodule

bind command_frame_builder_core cfb_checker u_cfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_frame_end (o_out.frame_end),
    .i_run_last  (o_out.run_last)
);
